// ----- rtl/bme_pkg.sv -----
// package for the byte modular exponentiation block
// holds configuration codes, reset values and the controller/datapath structs
// no dependencies
`timescale 1ns / 1ps

package bme_pkg;

    localparam int IN_W       = 8;
    localparam int OUT_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MODULUS  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_EXPONENT = t_cfg_idx'(1);

    localparam logic [CFG_DATA_W-1:0] MODULUS_RESET  = 16'd15943;
    localparam logic [CFG_DATA_W-1:0] EXPONENT_RESET = 16'd235;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // take a new request: acc = 1, sq = byte, exponent copy
        logic mul;       // form acc*sq and sq*sq
        logic step;      // one shift-subtract step of both reductions
        logic next;      // commit remainders, advance to the next exponent bit
        logic out_load;  // move the final value to the output register
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic exp_zero;
        logic mod_small;
    } t_sts;

endpackage

// ----- rtl/bme_datapath.sv -----
// datapath: configuration registers, two multipliers and two bit-serial remainder units
// depends on bme_pkg
`timescale 1ns / 1ps

module bme_datapath #(
    parameter int MOD_WIDTH = 16,
    parameter int EXP_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  bme_pkg::t_cfg_idx            i_cfg_index,
    input  logic [bme_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [bme_pkg::IN_W-1:0]     i_plain_byte,
    input  bme_pkg::t_cmd                i_cmd,
    output bme_pkg::t_sts                o_sts,
    output logic [MOD_WIDTH-1:0]         o_result
);

    localparam int PW = 2 * MOD_WIDTH;

    logic [bme_pkg::CFG_DATA_W-1:0] r_modulus;
    logic [bme_pkg::CFG_DATA_W-1:0] r_exponent;

    logic [MOD_WIDTH-1:0] r_acc;
    logic [MOD_WIDTH-1:0] r_sq;
    logic [EXP_WIDTH-1:0] r_exp;
    logic [PW-1:0]        r_pa;
    logic [PW-1:0]        r_ps;
    logic [MOD_WIDTH-1:0] r_ra;
    logic [MOD_WIDTH-1:0] r_rs;

    logic [MOD_WIDTH-1:0] w_m;
    logic [EXP_WIDTH-1:0] w_e;
    logic [MOD_WIDTH:0]   w_m_ext;
    logic [MOD_WIDTH:0]   w_ra_t;
    logic [MOD_WIDTH:0]   w_rs_t;
    logic [MOD_WIDTH:0]   n_ra;
    logic [MOD_WIDTH:0]   n_rs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= bme_pkg::MODULUS_RESET;
            r_exponent <= bme_pkg::EXPONENT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bme_pkg::CFG_MODULUS:  r_modulus  <= i_cfg_data;
                bme_pkg::CFG_EXPONENT: r_exponent <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_m     = MOD_WIDTH'(r_modulus);
    assign w_e     = EXP_WIDTH'(r_exponent);
    assign w_m_ext = {1'b0, w_m};

    assign o_sts.exp_zero  = (w_e == '0);
    assign o_sts.mod_small = (w_m < MOD_WIDTH'(2));

    // remainder stays below m, so the shifted value stays below 2m
    assign w_ra_t = {r_ra, r_pa[PW-1]};
    assign w_rs_t = {r_rs, r_ps[PW-1]};

    always_comb begin
        n_ra = (w_ra_t >= w_m_ext) ? (w_ra_t - w_m_ext) : w_ra_t;
        n_rs = (w_rs_t >= w_m_ext) ? (w_rs_t - w_m_ext) : w_rs_t;
    end

    // the byte goes in unreduced: every use of it passes through a reduction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc <= MOD_WIDTH'(1);
            r_sq  <= MOD_WIDTH'(i_plain_byte);
            r_exp <= w_e;
        end else if (i_cmd.next) begin
            if (r_exp[0]) begin
                r_acc <= r_ra;
            end
            r_sq  <= r_rs;
            r_exp <= r_exp >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_pa <= PW'(r_acc) * PW'(r_sq);
            r_ps <= PW'(r_sq) * PW'(r_sq);
            r_ra <= '0;
            r_rs <= '0;
        end else if (i_cmd.step) begin
            r_pa <= r_pa << 1;
            r_ps <= r_ps << 1;
            r_ra <= n_ra[MOD_WIDTH-1:0];
            r_rs <= n_rs[MOD_WIDTH-1:0];
        end
    end

    always_comb begin
        if (o_sts.exp_zero) begin
            o_result = MOD_WIDTH'(1);
        end else if (o_sts.mod_small) begin
            o_result = '0;
        end else begin
            o_result = r_acc;
        end
    end

endmodule

// ----- rtl/bme_ctrl.sv -----
// controller: sequences multiply, reduction and bit-advance steps for one request
// depends on bme_pkg
`timescale 1ns / 1ps

module bme_ctrl #(
    parameter int MOD_WIDTH = 16,
    parameter int EXP_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_free,
    input  bme_pkg::t_sts i_sts,
    output bme_pkg::t_cmd o_cmd,
    output logic          o_ready
);

    localparam int RCW = $clog2(2 * MOD_WIDTH);
    localparam int BCW = $clog2(EXP_WIDTH + 1);
    localparam logic [RCW-1:0] RED_LAST = RCW'(2 * MOD_WIDTH - 1);
    localparam logic [BCW-1:0] BIT_LAST = BCW'(EXP_WIDTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_RED,
        S_NEXT,
        S_FIN
    } t_state;

    t_state          r_state;
    logic [RCW-1:0]  r_rcnt;
    logic [BCW-1:0]  r_bcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rcnt  <= '0;
            r_bcnt  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_bcnt  <= '0;
                        r_state <= (i_sts.exp_zero || i_sts.mod_small) ? S_FIN : S_MUL;
                    end
                end
                S_MUL: begin
                    r_rcnt  <= '0;
                    r_state <= S_RED;
                end
                S_RED: begin
                    r_rcnt <= r_rcnt + RCW'(1);
                    if (r_rcnt == RED_LAST) begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_bcnt <= r_bcnt + BCW'(1);
                    r_state <= (r_bcnt == BIT_LAST) ? S_FIN : S_MUL;
                end
                S_FIN: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.step     = (r_state == S_RED);
        o_cmd.next     = (r_state == S_NEXT);
        o_cmd.out_load = (r_state == S_FIN) && i_out_free;
    end

endmodule

// ----- rtl/byte_modexp_encrypt_top.sv -----
// top level of the byte modular exponentiation block: controller, datapath, output register
// depends on bme_pkg, bme_ctrl, bme_datapath
`timescale 1ns / 1ps

// Raises each plaintext byte to the configured exponent modulo the configured modulus,
// right-to-left square-and-multiply, one request at a time. A request holds the block
// from its acceptance until its result is written to the output register, a write that
// waits while the result held there is stalled; the next byte is accepted after that.
// Each of the EXP_WIDTH exponent bits takes a multiply step, a shift-subtract step of
// the remainder units for each of the 2 * MOD_WIDTH product bits and a step to commit
// the remainders. An exponent of zero, or a modulus below two, skips these steps. The
// next byte is taken while a finished result still waits in the output register. A
// second finished result waits in the controller until the output register is free.
// Write configuration only while the block is idle.
module byte_modexp_encrypt_top #(
    parameter int MOD_WIDTH = 16,
    parameter int EXP_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bme_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bme_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [bme_pkg::IN_W-1:0]       i_plain_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [bme_pkg::OUT_W-1:0]      o_cipher_value
);

    bme_pkg::t_cmd        w_cmd;
    bme_pkg::t_sts        w_sts;
    logic [MOD_WIDTH-1:0] w_result;
    logic                 w_ready;
    logic                 w_out_free;

    logic                        r_out_valid;
    logic [bme_pkg::OUT_W-1:0]   r_cipher;

    assign w_out_free = !r_out_valid || !i_out_stall;

    bme_ctrl #(
        .MOD_WIDTH (MOD_WIDTH),
        .EXP_WIDTH (EXP_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_ready    (w_ready)
    );

    bme_datapath #(
        .MOD_WIDTH (MOD_WIDTH),
        .EXP_WIDTH (EXP_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (bme_pkg::t_cfg_idx'(i_cfg_index)),
        .i_cfg_data   (i_cfg_data),
        .i_plain_byte (i_plain_byte),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            r_cipher <= bme_pkg::OUT_W'(w_result);
        end
    end

    assign o_in_stall     = !w_ready;
    assign o_out_valid    = r_out_valid;
    assign o_cipher_value = r_cipher;

`ifndef NO_ASSERTIONS
    // a finished value must never overwrite one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");

    // one request at a time: an accepted byte closes the input
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after acceptance");

    // a result only appears after the controller hands one over
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.out_load))
        else $error("output valid without a finished request");
`endif

endmodule

// ----- sim/tb.sv -----
// testbench for byte_modexp_encrypt_top: directed and random requests under random idling
// predicts each cipher value by square-and-multiply and checks results in order
// depends on bme_pkg and byte_modexp_encrypt_top
`timescale 1ns / 1ps

module tb;

    localparam int    CLK_HALF_NS = 6;
    localparam longint LIMIT_NS   = 64'd18_000_000;

    localparam int IN_W       = bme_pkg::IN_W;
    localparam int OUT_W      = bme_pkg::OUT_W;
    localparam int CFG_IDX_W  = bme_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = bme_pkg::CFG_DATA_W;

    // indices past the register list, writes there are dropped
    localparam bme_pkg::t_cfg_idx CFG_SPARE_LO = bme_pkg::t_cfg_idx'(2);
    localparam bme_pkg::t_cfg_idx CFG_SPARE_HI = bme_pkg::t_cfg_idx'(3);

    typedef enum int { RX_READY, RX_LIGHT, RX_HEAVY, RX_BURSTY } t_rx_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [IN_W-1:0]       i_plain_byte;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [OUT_W-1:0]      o_cipher_value;

    logic [CFG_DATA_W-1:0] cur_modulus;
    logic [CFG_DATA_W-1:0] cur_exponent;
    logic [OUT_W-1:0]      cipher_q[$];
    int                    fail_count   = 0;
    bit                    in_offering  = 1'b0;

    t_rx_mode              rx_mode      = RX_READY;
    int                    hold_request = 0;
    int                    hold_left    = 0;
    logic [7:0]            rx_tick      = 8'd0;

    byte_modexp_encrypt_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_plain_byte  (i_plain_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_cipher_value(o_cipher_value)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // right-to-left square-and-multiply, every product reduced by the modulus
    function automatic logic [OUT_W-1:0] modexp_cipher(logic [IN_W-1:0] plain,
                                                       logic [CFG_DATA_W-1:0] modulus,
                                                       logic [CFG_DATA_W-1:0] exponent);
        longint unsigned acc;
        longint unsigned sq;
        longint unsigned m;
        if (exponent == '0) begin
            return OUT_W'(1);
        end
        if (modulus < 2) begin
            return '0;
        end
        m   = modulus;
        acc = 1;
        sq  = plain % m;
        for (int k = 0; k < CFG_DATA_W; k++) begin
            if (exponent[k]) begin
                acc = (acc * sq) % m;
            end
            sq = (sq * sq) % m;
        end
        return acc[OUT_W-1:0];
    endfunction

    // receiver: long hold-off when asked, otherwise the current stall pattern
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        rx_tick = rx_tick + 8'd1;
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            case (rx_mode)
                RX_READY:  i_out_stall <= 1'b0;
                RX_LIGHT:  i_out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY:  i_out_stall <= ($urandom_range(0, 9) < 7);
                RX_BURSTY: i_out_stall <= (rx_tick[5:3] >= 3'd5);
                default:   i_out_stall <= 1'b0;
            endcase
        end
    end

    // result checker, values seen here are those before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cipher_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %0d",
                         $time, o_cipher_value);
                fail_count++;
            end else begin
                if (o_cipher_value !== cipher_q[0]) begin
                    $display("%0t: cipher_value mismatch, expected %0d actual %0d",
                             $time, cipher_q[0], o_cipher_value);
                    fail_count++;
                end
                void'(cipher_q.pop_front());
            end
        end
    end

    task automatic send_byte(logic [IN_W-1:0] plain);
        i_in_valid   <= 1'b1;
        i_plain_byte <= plain;
        in_offering = 1'b1;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        cipher_q.push_back(modexp_cipher(plain, cur_modulus, cur_exponent));
    endtask

    task automatic pause_sender(int cycles);
        i_in_valid   <= 1'b0;
        i_plain_byte <= IN_W'($urandom);
        in_offering = 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic finish_outstanding();
        if (in_offering) begin
            i_in_valid <= 1'b0;
            in_offering = 1'b0;
        end
        while (cipher_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(bme_pkg::t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            bme_pkg::CFG_MODULUS:  cur_modulus  = data;
            bme_pkg::CFG_EXPONENT: cur_exponent = data;
            default:               ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [CFG_DATA_W-1:0] modulus,
                              logic [CFG_DATA_W-1:0] exponent);
        finish_outstanding();
        write_reg(bme_pkg::CFG_MODULUS, modulus);
        write_reg(bme_pkg::CFG_EXPONENT, exponent);
    endtask

    // bursts of requests with random gaps, now and then long enough to land mid-computation
    task automatic send_random_stream(int count);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 12);
            if (burst > left) begin
                burst = left;
            end
            repeat (burst) send_byte(IN_W'($urandom_range(0, 255)));
            left -= burst;
            case ($urandom_range(0, 7))
                0:       pause_sender($urandom_range(20, 700));
                1, 2:    ;
                default: pause_sender($urandom_range(1, 20));
            endcase
        end
    endtask

    task automatic test_reset_values();
        rx_mode = RX_READY;
        send_byte(8'd0);
        send_byte(8'd1);
        send_byte(8'd2);
        send_byte(8'd128);
        send_byte(8'd255);
    endtask

    task automatic test_extremes();
        rx_mode = RX_BURSTY;
        set_config(16'hFFFF, 16'hFFFF);
        send_byte(8'd255);
        send_byte(8'd0);
        set_config(16'd2, 16'd1);
        send_byte(8'd255);
        send_byte(8'd254);
        set_config(16'hFFFF, 16'd1);
        send_byte(8'd255);
        // only the top exponent bit set
        set_config(16'd40961, 16'h8000);
        send_byte(8'd3);
    endtask

    task automatic test_exponent_zero();
        rx_mode = RX_LIGHT;
        set_config(16'd15943, 16'd0);
        send_byte(8'd0);
        send_byte(8'd255);
        set_config(16'd0, 16'd0);
        send_byte(8'd9);
    endtask

    task automatic test_small_modulus();
        rx_mode = RX_HEAVY;
        set_config(16'd0, 16'd5);
        send_byte(8'd7);
        set_config(16'd1, 16'hFFFF);
        send_byte(8'd200);
    endtask

    task automatic test_ignored_index();
        rx_mode = RX_READY;
        set_config(16'd1009, 16'd17);
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'h0000);
        send_byte(8'd2);
        send_byte(8'd255);
    endtask

    // receiver holds off for several request times while the sender keeps offering
    task automatic test_backpressure();
        set_config(16'd65521, 16'hFFFF);
        rx_mode      = RX_READY;
        hold_request = 2500;
        repeat (8) send_byte(IN_W'($urandom_range(0, 255)));
        finish_outstanding();
    endtask

    task automatic test_random_settings();
        logic [CFG_DATA_W-1:0] m;
        logic [CFG_DATA_W-1:0] e;
        for (int phase = 0; phase < 8; phase++) begin
            m = CFG_DATA_W'($urandom_range(2, 65535));
            e = CFG_DATA_W'($urandom_range(0, 65535));
            case (phase)
                1: m = 16'hFFFF;
                2: m = 16'd2;
                3: e = 16'hFFFF;
                4: m = CFG_DATA_W'($urandom_range(2, 300));
                5: begin
                    m = CFG_DATA_W'($urandom_range(0, 65535));
                    e = CFG_DATA_W'($urandom_range(0, 3));
                end
                7: begin
                    m = bme_pkg::MODULUS_RESET;
                    e = bme_pkg::EXPONENT_RESET;
                end
                default: ;
            endcase
            set_config(m, e);
            rx_mode = t_rx_mode'(phase % 4);
            send_random_stream(50);
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= bme_pkg::CFG_MODULUS;
        i_cfg_data   <= '0;
        i_in_valid   <= 1'b0;
        i_plain_byte <= '0;
        i_out_stall  <= 1'b0;
        cur_modulus  = bme_pkg::MODULUS_RESET;
        cur_exponent = bme_pkg::EXPONENT_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_extremes();
        test_exponent_zero();
        test_small_modulus();
        test_ignored_index();
        test_backpressure();
        test_random_settings();

        finish_outstanding();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("%0t: timeout", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- byte_modexp_encrypt_top.f -----
rtl/bme_pkg.sv
rtl/bme_datapath.sv
rtl/bme_ctrl.sv
rtl/byte_modexp_encrypt_top.sv
sim/tb.sv
